[src/b64e_pkg.sv]
package b64e_pkg;

  // ascii codes of the alphabet ranges and padding
  localparam logic [6:0] CharUpperA = 7'h41;
  localparam logic [6:0] CharLowerA = 7'h61;
  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharPlus   = 7'h2B;
  localparam logic [6:0] CharSlash  = 7'h2F;
  localparam logic [6:0] PadChar    = 7'h3D;

  // characters per job and queue depth
  localparam int unsigned MaxChars = 4;
  localparam int unsigned IdxW     = $clog2(MaxChars);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhSecond = 2'd1,
    PhThird  = 2'd2
  } phase_e;

  // one byte's worth of characters for the back end
  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;
    logic [IdxW-1:0]          last_idx;
  } job_t;

  // map a six-bit value onto the standard alphabet
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = CharUpperA + {1'b0, v};
    end else if (v < 6'd52) begin
      r = CharLowerA + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      r = CharZero + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end else begin
      r = CharSlash;
    end
    return r;
  endfunction

endpackage

[src/b64e_front.sv]
module b64e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output b64e_pkg::job_t    push_job_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;

  // classify the byte by group phase and build its characters
  always_comb begin
    push_job_o.chars    = {MaxChars{PadChar}};
    push_job_o.last_idx = '0;
    phase_d = phase_q;
    carry_d = carry_q;
    unique case (phase_q)
      PhSecond: begin
        push_job_o.chars[0] = sextet_char({carry_q[1:0], data_byte_i[7:4]});
        if (end_of_message_i) begin
          push_job_o.chars[1] = sextet_char({data_byte_i[3:0], 2'b00});
          push_job_o.last_idx = IdxW'(2);
          phase_d = PhFirst;
          carry_d = '0;
        end else begin
          phase_d = PhThird;
          carry_d = data_byte_i[3:0];
        end
      end
      PhThird: begin
        push_job_o.chars[0] = sextet_char({carry_q, data_byte_i[7:6]});
        push_job_o.chars[1] = sextet_char(data_byte_i[5:0]);
        push_job_o.last_idx = IdxW'(1);
        phase_d = PhFirst;
        carry_d = '0;
      end
      default: begin
        push_job_o.chars[0] = sextet_char(data_byte_i[7:2]);
        if (end_of_message_i) begin
          push_job_o.chars[1] = sextet_char({data_byte_i[1:0], 4'b0000});
          push_job_o.last_idx = IdxW'(3);
          phase_d = PhFirst;
          carry_d = '0;
        end else begin
          phase_d = PhSecond;
          carry_d = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  // group state advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      carry_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

[src/b64e_queue.sv]
module b64e_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  b64e_pkg::job_t    wr_job_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output b64e_pkg::job_t    rd_job_o
);
  import b64e_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             wr_en, rd_en;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i & wr_ready_o;
  assign rd_en      = rd_ready_i & rd_valid_o;
  assign rd_job_o   = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/b64e_back.sv]
module b64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  b64e_pkg::job_t    pop_job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              final_char_o
);
  import b64e_pkg::*;

  job_t            job_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q, out_final_q;
  logic [6:0]      out_char_q;
  logic            out_load, emit, emit_last, pop;

  // output slot is free or drains this cycle
  assign out_load    = ~out_valid_q | out_ready_i;
  assign emit        = busy_q & out_load;
  assign emit_last   = (idx_q == job_q.last_idx);
  assign pop_ready_o = ~busy_q | (emit & emit_last);
  assign pop         = pop_ready_o & pop_valid_i;

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign final_char_o = out_final_q;

  // current job and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (emit) begin
      busy_q <= ~emit_last;
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q <= pop_job_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q  <= job_q.chars[idx_q];
      out_final_q <= emit_last;
    end
  end

endmodule

[src/base64_stream_encoder.sv]
// Streaming Base64 encoder, standard alphabet with '=' padding. One byte
// transfer on the input may happen every cycle while the two-entry job queue
// has room; each byte becomes one to four characters (one, one and two across
// a three-byte group, four or three on a final byte in the first or second
// position), and the output register sends one character per cycle while
// out_ready_i is high. On long messages throughput is set by this
// one-character output serializer. The first character of a byte passes the
// queue entry, the job register of the back end and the output register.
// final_char_o marks the last character produced by each input byte.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       final_char_o
);
  import b64e_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  // classify bytes and build characters
  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_job_o       (push_job)
  );

  // decouples front from back
  b64e_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_job_i   (push_job),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_job_o   (pop_job)
  );

  // serialize characters onto the output
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_job_i    (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .final_char_o (final_char_o)
  );

  // a run of characters continues without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !final_char_o |=> out_valid_o)
    else $error("gap inside a character run");

  // padding only ever follows with more padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_char_o == PadChar) && !final_char_o
    |=> out_char_o == PadChar)
    else $error("padding followed by a data character");

  // input stalls only while jobs are queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pop_valid)
    else $error("input stalled with empty job queue");

endmodule
